>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker module.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> hw/rtl/tmc_pkg.sv
// Types and constants of the transfer message checker.
// No dependencies; used by every module of the block.
package tmc_pkg;

    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 5;
    localparam int AMOUNT_W    = 64;
    localparam int COUNT_W     = 6;
    localparam int VARINT_W    = 21;
    localparam int VSHIFT_W    = 2;
    localparam int LANES       = AMOUNT_W / BYTE_W;
    localparam int LANE_W      = $clog2(LANES);

    localparam logic [VARINT_W-1:0] VARINT_MAX = 21'h00ffff;
    localparam logic [6:0]          GROUP_MASK = 7'h7f;
    localparam logic [COUNT_W-1:0]  HDR_LEN    = 6'd3;
    localparam logic [COUNT_W-1:0]  KEY_LEN    = 6'd32;
    localparam logic [COUNT_W-1:0]  ACCT_LEN   = 6'd2;
    localparam logic [COUNT_W-1:0]  TAG_LEN    = 6'd4;
    localparam logic [COUNT_W-1:0]  DATA_LEN   = 6'd12;

    // Parser phases, one-hot.
    typedef enum logic [13:0] {
        PH_HDR    = 14'b00000000000001,
        PH_KEYCNT = 14'b00000000000010,
        PH_SENDER = 14'b00000000000100,
        PH_RECV   = 14'b00000000001000,
        PH_PROG   = 14'b00000000010000,
        PH_HASH   = 14'b00000000100000,
        PH_INSCNT = 14'b00000001000000,
        PH_PIDX   = 14'b00000010000000,
        PH_ACNT   = 14'b00000100000000,
        PH_ACCTS  = 14'b00001000000000,
        PH_DLEN   = 14'b00010000000000,
        PH_DATA   = 14'b00100000000000,
        PH_DONE   = 14'b01000000000000,
        PH_DRAIN  = 14'b10000000000000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SENDER  = 2'd0,
        KIND_RECV    = 2'd1,
        KIND_HASH    = 2'd2,
        KIND_VERDICT = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_TRUNC     = 4'd1,
        ST_HEADER    = 4'd2,
        ST_KEYCNT    = 4'd3,
        ST_PROGRAM   = 4'd4,
        ST_INSCNT    = 4'd5,
        ST_PIDX      = 4'd6,
        ST_ACNT      = 4'd7,
        ST_ACCTS     = 4'd8,
        ST_DLEN      = 4'd9,
        ST_TAG       = 4'd10,
        ST_ZERO_AMT  = 4'd11,
        ST_TRAILING  = 4'd12,
        ST_OVERFLOW  = 4'd13,
        ST_OVERLONG  = 4'd14
    } status_t;

    // One result item.
    typedef struct packed {
        kind_t                kind;
        logic [BYTE_W-1:0]    out_byte;
        logic [IDX_W-1:0]     byte_index;
        status_t              status;
        logic                 self_transfer;
        logic [AMOUNT_W-1:0]  amount;
    } result_t;

endpackage

>>> hw/rtl/tmc_parse.sv
// Message parser: phase state and per-byte next-state logic.
// Depends on tmc_pkg.
module tmc_parse (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [tmc_pkg::BYTE_W-1:0]   data_byte,
    input  logic                         last_byte,
    input  logic                         advance,
    output logic                         res_valid,
    output tmc_pkg::result_t             res
);
    import tmc_pkg::*;

    phase_t               phase_reg,  phase_next;
    logic [COUNT_W-1:0]   count_reg,  count_next;
    logic [VARINT_W-1:0]  vv_reg,     vv_next;
    logic [VSHIFT_W-1:0]  vs_reg,     vs_next;
    logic                 self_reg,   self_next;
    status_t              err_reg,    err_next;
    logic [AMOUNT_W-1:0]  amt_reg,    amt_next;

    logic [COUNT_W-1:0]   count_inc;
    logic [VARINT_W-1:0]  v_acc;
    logic                 v_done;
    logic                 v_over;
    logic                 v_long;
    logic                 fwd;
    kind_t                fkind;
    logic                 fail_req;
    status_t              fail_code;
    logic                 adv;
    phase_t               adv_phase;
    logic [COUNT_W-1:0]   lane_off;
    logic [LANE_W-1:0]    lane;
    status_t              final_st;

    assign count_inc = count_reg + 1'b1;
    assign lane_off  = count_reg - TAG_LEN;
    assign lane      = lane_off[LANE_W-1:0];

    // Accumulate one compact-u16 group at the current shift.
    always_comb
    begin
        unique case (vs_reg)
            2'd0:    v_acc = vv_reg | {14'd0, data_byte[6:0] & GROUP_MASK};
            2'd1:    v_acc = vv_reg | {7'd0, data_byte[6:0] & GROUP_MASK, 7'd0};
            2'd2:    v_acc = vv_reg | {data_byte[6:0] & GROUP_MASK, 14'd0};
            default: v_acc = vv_reg;
        endcase
        v_done = !data_byte[7];
        v_over = v_done && (v_acc > VARINT_MAX);
        v_long = data_byte[7] && (vs_reg >= 2'd2);
    end

    // Next state and result for the item in the input register.
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        vv_next    = vv_reg;
        vs_next    = vs_reg;
        self_next  = self_reg;
        err_next   = err_reg;
        amt_next   = amt_reg;
        fwd        = 1'b0;
        fkind      = KIND_SENDER;
        fail_req   = 1'b0;
        fail_code  = ST_OK;
        adv        = 1'b0;
        adv_phase  = phase_reg;
        final_st   = ST_OK;
        res        = '0;

        unique case (phase_reg)
            PH_HDR:
            begin
                if (data_byte != ((count_reg == 6'd1) ? 8'd0 : 8'd1))
                    vv_next = 21'd1;
                count_next = count_inc;
                if (count_inc >= HDR_LEN)
                begin
                    if (vv_next != '0)
                    begin
                        fail_req  = 1'b1;
                        fail_code = ST_HEADER;
                    end
                    else
                    begin
                        adv       = 1'b1;
                        adv_phase = PH_KEYCNT;
                    end
                end
            end
            PH_KEYCNT, PH_INSCNT, PH_ACNT, PH_DLEN:
            begin
                vv_next = v_acc;
                if (phase_reg == PH_DLEN)
                    amt_next = '0;
                if (v_over)
                begin
                    fail_req  = 1'b1;
                    fail_code = ST_OVERFLOW;
                end
                else if (v_long)
                begin
                    fail_req  = 1'b1;
                    fail_code = ST_OVERLONG;
                end
                else if (!v_done)
                    vs_next = vs_reg + 1'b1;
                else
                begin
                    priority if (phase_reg == PH_KEYCNT)
                    begin
                        if (v_acc == 21'd2 || v_acc == 21'd3)
                        begin
                            self_next = (v_acc == 21'd2);
                            adv       = 1'b1;
                            adv_phase = PH_SENDER;
                        end
                        else
                        begin
                            fail_req  = 1'b1;
                            fail_code = ST_KEYCNT;
                        end
                    end
                    else if (phase_reg == PH_INSCNT)
                    begin
                        fail_req  = (v_acc != 21'd1);
                        fail_code = ST_INSCNT;
                        adv       = 1'b1;
                        adv_phase = PH_PIDX;
                    end
                    else if (phase_reg == PH_ACNT)
                    begin
                        fail_req  = (v_acc != 21'd2);
                        fail_code = ST_ACNT;
                        adv       = 1'b1;
                        adv_phase = PH_ACCTS;
                    end
                    else
                    begin
                        fail_req  = (v_acc != 21'd12);
                        fail_code = ST_DLEN;
                        adv       = 1'b1;
                        adv_phase = PH_DATA;
                    end
                end
            end
            PH_SENDER, PH_RECV, PH_HASH:
            begin
                fwd        = 1'b1;
                fkind      = (phase_reg == PH_SENDER) ? KIND_SENDER :
                             (phase_reg == PH_RECV)   ? KIND_RECV : KIND_HASH;
                count_next = count_inc;
                if (count_inc >= KEY_LEN)
                begin
                    adv = 1'b1;
                    if (phase_reg == PH_SENDER)
                        adv_phase = self_reg ? PH_PROG : PH_RECV;
                    else if (phase_reg == PH_RECV)
                        adv_phase = PH_PROG;
                    else
                        adv_phase = PH_INSCNT;
                end
            end
            PH_PROG:
            begin
                if (data_byte != 8'd0)
                    vv_next = 21'd1;
                count_next = count_inc;
                if (count_inc >= KEY_LEN)
                begin
                    fail_req  = (vv_next != '0);
                    fail_code = ST_PROGRAM;
                    adv       = 1'b1;
                    adv_phase = PH_HASH;
                end
            end
            PH_PIDX:
            begin
                fail_req  = (data_byte != (self_reg ? 8'd1 : 8'd2));
                fail_code = ST_PIDX;
                adv       = 1'b1;
                adv_phase = PH_ACNT;
            end
            PH_ACCTS:
            begin
                if (data_byte != ((count_reg == 6'd0 || self_reg) ? 8'd0 : 8'd1))
                    vv_next = 21'd1;
                count_next = count_inc;
                if (count_inc >= ACCT_LEN)
                begin
                    fail_req  = (vv_next != '0);
                    fail_code = ST_ACCTS;
                    adv       = 1'b1;
                    adv_phase = PH_DLEN;
                end
            end
            PH_DATA:
            begin
                if (count_reg < TAG_LEN)
                begin
                    if (data_byte != ((count_reg == 6'd0) ? 8'd2 : 8'd0))
                        vv_next = 21'd1;
                end
                else
                begin
                    // OR the byte into its little-endian lane
                    for (int i = 0; i < LANES; i++)
                    begin
                        if (lane == LANE_W'(i))
                            amt_next[BYTE_W*i +: BYTE_W] =
                                amt_reg[BYTE_W*i +: BYTE_W] | data_byte;
                    end
                end
                count_next = count_inc;
                if (count_inc >= DATA_LEN)
                begin
                    if (vv_next != '0)
                    begin
                        fail_req  = 1'b1;
                        fail_code = ST_TAG;
                    end
                    else if (amt_next == '0)
                    begin
                        fail_req  = 1'b1;
                        fail_code = ST_ZERO_AMT;
                    end
                    else
                    begin
                        adv       = 1'b1;
                        adv_phase = PH_DONE;
                    end
                end
            end
            PH_DONE:
            begin
                fail_req  = 1'b1;
                fail_code = ST_TRAILING;
            end
            default:
                phase_next = PH_DRAIN;
        endcase

        // Keep the first error and drain; otherwise move on
        if (fail_req)
        begin
            if (err_reg == ST_OK)
                err_next = fail_code;
            phase_next = PH_DRAIN;
        end
        else if (adv)
        begin
            phase_next = adv_phase;
            count_next = '0;
            vv_next    = '0;
            vs_next    = '0;
        end

        // Build the verdict on the final byte and rearm
        if (last_byte)
        begin
            final_st = (err_next == ST_OK && phase_next != PH_DONE) ? ST_TRUNC : err_next;
            res.kind          = KIND_VERDICT;
            res.status        = final_st;
            res.self_transfer = (final_st == ST_OK) ? self_next : 1'b0;
            res.amount        = (final_st == ST_OK) ? amt_next : '0;
            phase_next = PH_HDR;
            count_next = '0;
            vv_next    = '0;
            vs_next    = '0;
            self_next  = 1'b0;
            err_next   = ST_OK;
            amt_next   = '0;
        end
        else if (fwd)
        begin
            res.kind          = fkind;
            res.out_byte      = data_byte;
            res.byte_index    = count_reg[IDX_W-1:0];
            res.self_transfer = self_reg;
        end
    end

    assign res_valid = last_byte || fwd;

    // Advance the parser state on each consumed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            count_reg <= '0;
            vv_reg    <= '0;
            vs_reg    <= '0;
            self_reg  <= 1'b0;
            err_reg   <= ST_OK;
            amt_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            vv_reg    <= vv_next;
            vs_reg    <= vs_next;
            self_reg  <= self_next;
            err_reg   <= err_next;
            amt_reg   <= amt_next;
        end
    end

endmodule

>>> hw/rtl/tmc_out_stage.sv
// Output register holding one result item toward the receiver.
// Depends on tmc_pkg.
module tmc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  tmc_pkg::result_t  load_data,
    input  logic              out_stall,
    output logic              out_free,
    output logic              out_valid,
    output tmc_pkg::result_t  out_data
);
    import tmc_pkg::*;

    logic     valid_reg, valid_next;
    result_t  data_reg;

    assign out_free   = !valid_reg || !out_stall;
    assign valid_next = out_free ? load : valid_reg;

    // Hold the valid flag while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture a new item only when the slot frees
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hw/rtl/transfer_message_checker_core.sv
// Top level of the transfer message checker.
// Depends on tmc_pkg, tmc_parse and tmc_out_stage.
//
// Input channel: in_valid / in_stall carry one message byte per item
// (data_byte, last_byte). Output channel: out_valid / out_stall carry
// one result item (kind, out_byte, byte_index, status, self_transfer,
// amount). Sender, receiver and blockhash bytes come out as they pass;
// the item with last_byte set yields a single verdict and rearms the
// parser for the next message. Other bytes yield nothing.
// Throughput: one byte per cycle when no stall holds it, set by the
// combinational phase update in the parser between the input register and
// the output register, from which the result of an accepted byte is offered.
// When the receiver stalls, the output register holds its item and the
// input register keeps the next byte; a byte that yields no result still
// moves through. in_stall rises only when both registers are full.
// Reset clears both valid flags and puts the parser in its header phase;
// no clearing pass is needed.
module transfer_message_checker_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [tmc_pkg::BYTE_W-1:0]     data_byte,
    input  logic                           last_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     kind,
    output logic [tmc_pkg::BYTE_W-1:0]     out_byte,
    output logic [tmc_pkg::IDX_W-1:0]      byte_index,
    output logic [3:0]                     status,
    output logic                           self_transfer,
    output logic [tmc_pkg::AMOUNT_W-1:0]   amount
);
    import tmc_pkg::*;

    logic               s1_valid_reg, s1_valid_next;
    logic [BYTE_W-1:0]  s1_byte_reg;
    logic               s1_last_reg;
    logic               s1_fire;
    logic               in_take;
    logic               res_valid;
    result_t            res;
    logic               out_free;
    result_t            out_data;

    // Consume the held byte when its result has somewhere to go
    assign s1_fire       = s1_valid_reg && (!res_valid || out_free);
    assign in_stall      = s1_valid_reg && !s1_fire;
    assign in_take       = in_valid && !in_stall;
    assign s1_valid_next = in_take ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // Capture the accepted byte
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    tmc_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .advance   (s1_fire),
        .res_valid (res_valid),
        .res       (res)
    );

    tmc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_fire && res_valid),
        .load_data (res),
        .out_stall (out_stall),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign kind          = out_data.kind;
    assign out_byte      = out_data.out_byte;
    assign byte_index    = out_data.byte_index;
    assign status        = out_data.status;
    assign self_transfer = out_data.self_transfer;
    assign amount        = out_data.amount;

endmodule

>>> hw/rtl/tmc_checker.sv
// Port-level checks of the transfer message checker, bound to the top level.
// Depends on tmc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tmc_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [tmc_pkg::BYTE_W-1:0]     data_byte,
    input  logic                           last_byte,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [1:0]                     kind,
    input  logic [tmc_pkg::BYTE_W-1:0]     out_byte,
    input  logic [tmc_pkg::IDX_W-1:0]      byte_index,
    input  logic [3:0]                     status,
    input  logic                           self_transfer,
    input  logic [tmc_pkg::AMOUNT_W-1:0]   amount
);
    import tmc_pkg::*;

    logic out_hold;
    logic is_verdict;

    assign out_hold   = out_valid && out_stall;
    assign is_verdict = out_valid && (kind == KIND_VERDICT);

    // A stalled item stays offered with kind, byte, status and amount unchanged
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_hold,
        out_valid && $stable(kind) && $stable(out_byte) && $stable(status) && $stable(amount))

    // A failed verdict carries no self flag and no amount
    `ASSERT_SAME(a_fail_clean, clk, rst_n, is_verdict && (status != ST_OK),
        !self_transfer && (amount == '0))

    // A verdict forwards no byte
    `ASSERT_SAME(a_verdict_zero, clk, rst_n, is_verdict,
        (out_byte == '0) && (byte_index == '0))

    // A forwarded byte carries ok status and no amount
    `ASSERT_SAME(a_fwd_clean, clk, rst_n, out_valid && (kind != KIND_VERDICT),
        (status == ST_OK) && (amount == '0))

    // Data and last flags are unused here, beyond the bind
    logic unused_in;
    assign unused_in = in_valid ^ in_stall ^ last_byte ^ (^data_byte);

endmodule

bind transfer_message_checker_core tmc_checker u_tmc_checker (.*);
